FILE: hdl/bfsd_pkg.sv
`default_nettype none

package bfsd_pkg;

  localparam int KIND_W  = 3;
  localparam int BYTE_W  = 8;
  localparam int VALUE_W = 64;
  localparam int CNT_W   = 4;
  localparam int ACC_W   = 32;

  // Field kinds, same coding on op and kind
  localparam logic [KIND_W-1:0] KIND_BYTE  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SHORT = 3'd1;
  localparam logic [KIND_W-1:0] KIND_INT   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_LONG  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_SVAR  = 3'd4;
  localparam logic [KIND_W-1:0] KIND_UVAR  = 3'd5;

  localparam logic [CNT_W-1:0] CNT_MAX = 4'd15;

  typedef struct packed {
    logic [KIND_W-1:0] op;
    logic [BYTE_W-1:0] data_byte;
  } item_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [KIND_W-1:0]  kind;
    logic               overflow;
  } result_t;

endpackage

`default_nettype wire

FILE: hdl/bfsd_in_if.sv
`default_nettype none

interface bfsd_in_if;
  logic                           valid;
  logic                           ready;
  logic [bfsd_pkg::KIND_W-1:0]    op;
  logic [bfsd_pkg::BYTE_W-1:0]    data_byte;

  modport source (output valid, output op, output data_byte, input ready);
  modport sink (input valid, input op, input data_byte, output ready);
endinterface

`default_nettype wire

FILE: hdl/bfsd_out_if.sv
`default_nettype none

interface bfsd_out_if;
  logic                           valid;
  logic                           ready;
  logic signed [bfsd_pkg::VALUE_W-1:0] value;
  logic [bfsd_pkg::KIND_W-1:0]    kind;
  logic                           overflow;

  modport source (output valid, output value, output kind, output overflow, input ready);
  modport sink (input valid, input value, input kind, input overflow, output ready);
endinterface

`default_nettype wire

FILE: hdl/bfsd_in_reg.sv
`default_nettype none

module bfsd_in_reg (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            req_valid,
  output logic                 req_ready,
  input  wire bfsd_pkg::item_t req_item,
  input  wire logic            advance,
  output logic                 hold_valid,
  output bfsd_pkg::item_t      hold_item
);

  logic            valid_r;
  logic            valid_nxt;
  bfsd_pkg::item_t item_r;

  // Take a new request when empty or when the held one moves on
  assign req_ready = !valid_r || advance;

  always_comb begin
    valid_nxt = valid_r;
    if (req_ready) begin
      valid_nxt = req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req_ready && req_valid) begin
      item_r <= req_item;
    end
  end

  assign hold_valid = valid_r;
  assign hold_item  = item_r;

endmodule

`default_nettype wire

FILE: hdl/bfsd_decode.sv
`default_nettype none

module bfsd_decode (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            step,
  input  wire bfsd_pkg::item_t item,
  output logic                 res_valid,
  output bfsd_pkg::result_t    res
);

  logic [bfsd_pkg::VALUE_W-1:0] acc_r, acc_nxt;
  logic [bfsd_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                         active_r, active_nxt;
  logic [bfsd_pkg::KIND_W-1:0]  kind_r, kind_nxt;
  logic                         ovf_r, ovf_nxt;

  always_comb begin
    logic                         start;
    logic [bfsd_pkg::KIND_W-1:0]  k;
    logic [bfsd_pkg::VALUE_W-1:0] acc_e;
    logic [bfsd_pkg::CNT_W-1:0]   cnt_e;
    logic                         ovf_e;
    logic [bfsd_pkg::BYTE_W-1:0]  b;
    logic [bfsd_pkg::VALUE_W-1:0] shifted;
    logic [bfsd_pkg::CNT_W-1:0]   cnt_inc;
    logic [bfsd_pkg::CNT_W-1:0]   need;
    logic [6:0]                   grp;
    logic [bfsd_pkg::ACC_W-1:0]   grp_sh;
    logic [bfsd_pkg::ACC_W-1:0]   acc32;
    logic [bfsd_pkg::ACC_W-1:0]   mag;
    logic                         ovf_add;
    logic                         emit;

    start   = !active_r;
    k       = start ? item.op : kind_r;
    acc_e   = start ? '0 : acc_r;
    cnt_e   = start ? '0 : cnt_r;
    ovf_e   = start ? 1'b0 : ovf_r;
    b       = item.data_byte;
    shifted = {acc_e[bfsd_pkg::VALUE_W-bfsd_pkg::BYTE_W-1:0], b};
    cnt_inc = bfsd_pkg::CNT_W'(cnt_e + 4'd1);
    need    = bfsd_pkg::CNT_W'(4'd1 << k[1:0]);
    emit    = 1'b0;

    // Last group of a signed varint carries six bits, the sign sits above
    grp = (!b[7] && k == bfsd_pkg::KIND_SVAR) ? {1'b0, b[5:0]} : b[6:0];

    unique case (cnt_e)
      4'd0:    grp_sh = {25'd0, grp};
      4'd1:    grp_sh = {18'd0, grp, 7'd0};
      4'd2:    grp_sh = {11'd0, grp, 14'd0};
      4'd3:    grp_sh = {4'd0, grp, 21'd0};
      4'd4:    grp_sh = {grp[3:0], 28'd0};
      default: grp_sh = '0;
    endcase
    ovf_add = (cnt_e == 4'd4 && grp[6:4] != 3'd0) || (cnt_e > 4'd4 && grp != 7'd0);
    acc32   = acc_e[bfsd_pkg::ACC_W-1:0] | grp_sh;
    mag     = b[6] ? (32'd0 - acc32) : acc32;

    acc_nxt    = acc_r;
    cnt_nxt    = cnt_r;
    active_nxt = active_r;
    kind_nxt   = kind_r;
    ovf_nxt    = ovf_r;
    res        = '0;
    res.kind   = k;
    res.overflow = ovf_e;

    // Unused kind at a field start: drop the byte and stay idle
    if (step && !(start && k > bfsd_pkg::KIND_UVAR)) begin
      active_nxt = 1'b1;
      kind_nxt   = k;
      if (k <= bfsd_pkg::KIND_LONG) begin
        acc_nxt = shifted;
        cnt_nxt = cnt_inc;
        ovf_nxt = ovf_e;
        if (cnt_inc >= need) begin
          emit = 1'b1;
          unique case (k[1:0])
            2'd0:    res.value = {{56{shifted[7]}}, shifted[7:0]};
            2'd1:    res.value = {{48{shifted[15]}}, shifted[15:0]};
            2'd2:    res.value = {{32{shifted[31]}}, shifted[31:0]};
            default: res.value = shifted;
          endcase
        end
      end else begin
        acc_nxt = {32'd0, acc32};
        ovf_nxt = ovf_e | ovf_add;
        if (b[7]) begin
          cnt_nxt = (cnt_e < bfsd_pkg::CNT_MAX) ? cnt_inc : cnt_e;
        end else begin
          emit         = 1'b1;
          res.overflow = ovf_e | ovf_add;
          if (k == bfsd_pkg::KIND_SVAR) begin
            res.value = {{32{mag[31]}}, mag};
          end else begin
            res.value = {32'd0, acc32};
          end
        end
      end
      // Clear the field once its value leaves
      if (emit) begin
        acc_nxt    = '0;
        cnt_nxt    = '0;
        active_nxt = 1'b0;
        kind_nxt   = bfsd_pkg::KIND_BYTE;
        ovf_nxt    = 1'b0;
      end
    end
    res_valid = emit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r    <= '0;
      cnt_r    <= '0;
      active_r <= 1'b0;
      kind_r   <= bfsd_pkg::KIND_BYTE;
      ovf_r    <= 1'b0;
    end else begin
      acc_r    <= acc_nxt;
      cnt_r    <= cnt_nxt;
      active_r <= active_nxt;
      kind_r   <= kind_nxt;
      ovf_r    <= ovf_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/binary_field_stream_decoder.sv
// Binary field stream decoder.
//
// in_ch carries one raw stream byte per request together with op, the field
// kind, which is only looked at when a new field starts (0 byte, 1 short,
// 2 int, 3 long, 4 signed varint, 5 unsigned varint; 6 and 7 drop the byte).
// out_ch carries one request per completed field: value sign-extended to
// 64 bits (zero-extended for an unsigned varint), its kind and an overflow
// flag for varint bits above bit 31.
//
// Throughput is one byte per cycle while the receiver takes results: a single
// decode step updates the field state between the input and result registers.
// A byte that ends a field is decoded while held in the input register; its
// result is loaded into the result register and shows on out_ch from there.
//
// When the receiver stalls, the result register holds its request and the
// input register holds the next byte; in_ch.ready drops only while both are
// full. Reset (rst_n low, synchronous) empties both registers and clears the
// field state, so the next byte starts a new field.
`default_nettype none

module binary_field_stream_decoder (
  input  wire logic   clk,
  input  wire logic   rst_n,
  bfsd_in_if.sink     in_ch,
  bfsd_out_if.source  out_ch
);

  logic               advance;
  logic               hold_valid;
  bfsd_pkg::item_t    in_item;
  bfsd_pkg::item_t    hold_item;
  logic               res_valid;
  bfsd_pkg::result_t  res;
  logic               out_valid_r, out_valid_nxt;
  bfsd_pkg::result_t  out_res_r;

  assign in_item = '{op: in_ch.op, data_byte: in_ch.data_byte};

  // Advance the pipe whenever the result register is free or being drained
  assign advance = !out_valid_r || out_ch.ready;

  bfsd_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (in_ch.valid),
    .req_ready  (in_ch.ready),
    .req_item   (in_item),
    .advance    (advance),
    .hold_valid (hold_valid),
    .hold_item  (hold_item)
  );

  // Decode the held byte only when it can move on this cycle
  bfsd_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (hold_valid && advance),
    .item      (hold_item),
    .res_valid (res_valid),
    .res       (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Load the result only when a field completes; hold it otherwise
  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.value    = out_res_r.value;
  assign out_ch.kind     = out_res_r.kind;
  assign out_ch.overflow = out_res_r.overflow;

  // A stalled input means both registers are full and the receiver waits
  a_ready_low: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (hold_valid && out_valid_r && !out_ch.ready))
    else $error("input stalled without a full pipe");

  // Overflow is only ever flagged on varint fields
  a_ovf_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.overflow) |->
      (out_res_r.kind == bfsd_pkg::KIND_SVAR || out_res_r.kind == bfsd_pkg::KIND_UVAR))
    else $error("overflow on a fixed-width field");

  // A byte field is the sign extension of its low eight bits
  a_byte_sext: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.kind == bfsd_pkg::KIND_BYTE) |->
      (out_res_r.value[63:7] == '0 || out_res_r.value[63:7] == '1))
    else $error("byte field not sign-extended");

  // Unused kinds never reach the result register
  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_res_r.kind <= bfsd_pkg::KIND_UVAR))
    else $error("result with an unused kind");

endmodule

`default_nettype wire
